// ----- sv/lse_pkg.sv -----
// Shared types, codes and defaults for the LIFO stack engine.
package lse_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int DATA_WIDTH_DEF  = 32;

    localparam int REQ_W       = 3;
    localparam int VAL_W       = 32;
    localparam int STAT_W      = 2;
    localparam int DEPTH_OUT_W = 7;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH     = 3'd0,
        REQ_POP      = 3'd1,
        REQ_PEEK     = 3'd2,
        REQ_CLEAR    = 3'd3,
        REQ_TRAVERSE = 3'd4
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_TRAV
    } t_state;

    // datapath command, one per cycle
    typedef enum logic [3:0] {
        DP_NOP,
        DP_PUSH,
        DP_PUSH_FULL,
        DP_POP,
        DP_PEEK,
        DP_EMPTY,
        DP_CLEAR,
        DP_TRAV_START,
        DP_RD_DONE,
        DP_TRAV_STEP
    } t_dp_op;

    // datapath status back to the controller
    typedef struct packed {
        logic empty;
        logic full;
        logic trav_last;
    } t_dp_stat;

endpackage

// ----- sv/lse_ram.sv -----
// Generic single-port-write, registered-read RAM.
module lse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/lse_ctrl.sv -----
// Request sequencer: decodes requests and steps the datapath.
module lse_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [lse_pkg::REQ_W-1:0] i_req_type,
    input  lse_pkg::t_dp_stat     i_stat,
    output logic                  o_busy,
    output lse_pkg::t_dp_op       o_op
);
    import lse_pkg::*;

    t_state r_state, n_state;
    t_req   w_req;

    assign w_req = t_req'(i_req_type);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (w_req)
                        REQ_POP, REQ_PEEK: begin
                            if (!i_stat.empty) n_state = S_READ;
                        end
                        REQ_TRAVERSE: begin
                            if (!i_stat.empty) n_state = S_TRAV;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_READ:  n_state = S_IDLE;
            S_TRAV: begin
                if (i_stat.trav_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_busy = (r_state != S_IDLE);
        o_op   = DP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (w_req)
                        REQ_PUSH:     o_op = i_stat.full  ? DP_PUSH_FULL : DP_PUSH;
                        REQ_POP:      o_op = i_stat.empty ? DP_EMPTY : DP_POP;
                        REQ_PEEK:     o_op = i_stat.empty ? DP_EMPTY : DP_PEEK;
                        REQ_CLEAR:    o_op = DP_CLEAR;
                        REQ_TRAVERSE: o_op = i_stat.empty ? DP_NOP : DP_TRAV_START;
                        default:      o_op = DP_NOP;
                    endcase
                end
            end
            S_READ:  o_op = DP_RD_DONE;
            S_TRAV:  o_op = DP_TRAV_STEP;
            default: o_op = DP_NOP;
        endcase
    end

endmodule

// ----- sv/lse_datapath.sv -----
// Stack datapath: fill count, element RAM, traverse pointer and result register.
module lse_datapath #(
    parameter int STACK_DEPTH = lse_pkg::STACK_DEPTH_DEF,
    parameter int DATA_WIDTH  = lse_pkg::DATA_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lse_pkg::t_dp_op                   i_op,
    input  logic [lse_pkg::VAL_W-1:0]         i_push_value,
    input  logic                              i_traverse_dir,
    output lse_pkg::t_dp_stat                 o_stat,
    output logic                              o_valid,
    output logic [lse_pkg::STAT_W-1:0]        o_status,
    output logic [lse_pkg::VAL_W-1:0]         o_out_value,
    output logic [lse_pkg::DEPTH_OUT_W-1:0]   o_depth_now,
    output logic                              o_last_of_run
);
    import lse_pkg::*;

    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    logic [CNT_W-1:0]       r_count, n_count;
    logic [AW-1:0]          r_pos, n_pos;
    logic                   r_dir, n_dir;

    logic                   r_valid, n_valid;
    t_status                r_status, n_status;
    logic [VAL_W-1:0]       r_value, n_value;
    logic [DEPTH_OUT_W-1:0] r_depth, n_depth;
    logic                   r_last, n_last;

    logic [AW-1:0]          w_top, w_next_pos;
    logic                   w_empty, w_full, w_trav_last;
    logic                   w_we, w_re;
    logic [AW-1:0]          w_raddr;
    logic [DATA_WIDTH-1:0]  w_wdata, w_rdata;

    assign w_top       = AW'(r_count - CNT_W'(1));
    assign w_next_pos  = r_pos + AW'(1);
    assign w_empty     = (r_count == '0);
    assign w_full      = (r_count == CNT_W'(STACK_DEPTH));
    assign w_trav_last = (CNT_W'(r_pos) == r_count - CNT_W'(1));
    assign w_wdata     = DATA_WIDTH'(i_push_value);

    assign o_stat.empty     = w_empty;
    assign o_stat.full      = w_full;
    assign o_stat.trav_last = w_trav_last;

    // RAM port control
    always_comb begin
        w_we    = (i_op == DP_PUSH);
        w_re    = 1'b0;
        w_raddr = w_top;
        case (i_op)
            DP_POP, DP_PEEK: begin
                w_re    = 1'b1;
                w_raddr = w_top;
            end
            DP_TRAV_START: begin
                w_re    = 1'b1;
                w_raddr = i_traverse_dir ? w_top : '0;
            end
            DP_TRAV_STEP: begin
                w_re    = !w_trav_last;
                w_raddr = r_dir ? (w_top - w_next_pos) : w_next_pos;
            end
            default: w_re = 1'b0;
        endcase
    end

    lse_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(r_count)),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // count, pointer and result
    always_comb begin
        n_count  = r_count;
        n_pos    = r_pos;
        n_dir    = r_dir;
        n_valid  = 1'b0;
        n_status = r_status;
        n_value  = r_value;
        n_depth  = r_depth;
        n_last   = r_last;
        case (i_op)
            DP_PUSH: begin
                n_count  = r_count + CNT_W'(1);
                n_valid  = 1'b1;
                n_status = ST_OK;
                n_value  = '0;
                n_depth  = DEPTH_OUT_W'(r_count + CNT_W'(1));
                n_last   = 1'b1;
            end
            DP_PUSH_FULL: begin
                n_valid  = 1'b1;
                n_status = ST_FULL;
                n_value  = '0;
                n_depth  = DEPTH_OUT_W'(r_count);
                n_last   = 1'b1;
            end
            DP_POP: begin
                n_count = r_count - CNT_W'(1);
            end
            DP_EMPTY: begin
                n_valid  = 1'b1;
                n_status = ST_EMPTY;
                n_value  = '0;
                n_depth  = '0;
                n_last   = 1'b1;
            end
            DP_CLEAR: begin
                n_count  = '0;
                n_valid  = 1'b1;
                n_status = ST_OK;
                n_value  = '0;
                n_depth  = '0;
                n_last   = 1'b1;
            end
            DP_TRAV_START: begin
                n_pos = '0;
                n_dir = i_traverse_dir;
            end
            DP_RD_DONE: begin
                n_valid  = 1'b1;
                n_status = ST_OK;
                n_value  = VAL_W'(w_rdata);
                n_depth  = DEPTH_OUT_W'(r_count);
                n_last   = 1'b1;
            end
            DP_TRAV_STEP: begin
                n_pos    = w_next_pos;
                n_valid  = 1'b1;
                n_status = ST_OK;
                n_value  = VAL_W'(w_rdata);
                n_depth  = DEPTH_OUT_W'(r_count);
                n_last   = w_trav_last;
            end
            default: n_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_dir    <= n_dir;
        r_status <= n_status;
        r_value  <= n_value;
        r_depth  <= n_depth;
        r_last   <= n_last;
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_out_value   = r_value;
    assign o_depth_now   = r_depth;
    assign o_last_of_run = r_last;

endmodule

// ----- sv/lifo_stack_engine.sv -----
// Top level of the LIFO stack engine: request sequencer plus stack datapath.
//
//  channel   direction  transfer when        fields
//  -------   ---------  -------------------  ---------------------------------------------
//  request   in         i_start && !o_busy   i_req_type, i_push_value, i_traverse_dir
//  result    out        o_valid (one cycle)  o_status, o_out_value, o_depth_now,
//                                            o_last_of_run
//
//  Push, clear, and pop/peek on an empty stack: result in the cycle after the
//  request transfer, and busy stays low, so one such request per cycle.
//  Pop and peek on a non-empty stack: the element RAM read is registered, then
//  the read state loads the result register; busy is high in that read state.
//  Traverse of N elements: N results back to back, one RAM read each; busy is
//  high until the last result is loaded.
//  Reset (i_rst_n low, synchronous) clears the fill count and the sequencer;
//  the RAM is not cleared. Results cannot be stalled by the receiver.
module lifo_stack_engine #(
    parameter int STACK_DEPTH = lse_pkg::STACK_DEPTH_DEF,
    parameter int DATA_WIDTH  = lse_pkg::DATA_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic [lse_pkg::REQ_W-1:0]        i_req_type,
    input  logic [lse_pkg::VAL_W-1:0]        i_push_value,
    input  logic                             i_traverse_dir,
    output logic                             o_valid,
    output logic [lse_pkg::STAT_W-1:0]       o_status,
    output logic [lse_pkg::VAL_W-1:0]        o_out_value,
    output logic [lse_pkg::DEPTH_OUT_W-1:0]  o_depth_now,
    output logic                             o_last_of_run
);
    import lse_pkg::*;

    t_dp_op   w_op;
    t_dp_stat w_stat;

    // sequencer: accepts requests in idle, walks pop/peek reads and traverses
    lse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_req_type (i_req_type),
        .i_stat     (w_stat),
        .o_busy     (o_busy),
        .o_op       (w_op)
    );

    // datapath: fill count, element RAM, traverse pointer, result register
    lse_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (w_op),
        .i_push_value   (i_push_value),
        .i_traverse_dir (i_traverse_dir),
        .o_stat         (w_stat),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_out_value    (o_out_value),
        .o_depth_now    (o_depth_now),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

// ----- tb/lse_checker.sv -----
// Checker for the LIFO stack engine: tracks stack contents, predicts results, compares.
module lse_checker #(
    parameter int DEPTH = lse_pkg::STACK_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic                               i_busy,
    input  logic [lse_pkg::REQ_W-1:0]          i_req_type,
    input  logic [lse_pkg::VAL_W-1:0]          i_push_value,
    input  logic                               i_traverse_dir,
    input  logic                               i_valid,
    input  logic [lse_pkg::STAT_W-1:0]         i_status,
    input  logic [lse_pkg::VAL_W-1:0]          i_out_value,
    input  logic [lse_pkg::DEPTH_OUT_W-1:0]    i_depth_now,
    input  logic                               i_last_of_run,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_result_count,
    output int                                 o_full_hits,
    output int                                 o_empty_hits
);
    import lse_pkg::*;

    typedef struct packed {
        t_status                  status;
        logic [VAL_W-1:0]         value;
        logic [DEPTH_OUT_W-1:0]   depth;
        logic                     last;
    } t_stack_result;

    logic [VAL_W-1:0] stack_mem [DEPTH];
    int               stack_fill;
    t_stack_result    awaited_q [$];

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_result_count = 0;
        o_full_hits    = 0;
        o_empty_hits   = 0;
        stack_fill     = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    task automatic queue_result(input t_status st, input logic [VAL_W-1:0] val,
                                input int depth, input logic last);
        t_stack_result r;
        r.status = st;
        r.value  = val;
        r.depth  = DEPTH_OUT_W'(depth);
        r.last   = last;
        awaited_q.push_back(r);
    endtask

    task automatic predict_request(input logic [REQ_W-1:0] req,
                                   input logic [VAL_W-1:0] val, input logic dir);
        int idx;
        case (req)
            REQ_PUSH: begin
                if (stack_fill >= DEPTH) begin
                    queue_result(ST_FULL, '0, stack_fill, 1'b1);
                    o_full_hits++;
                end else begin
                    stack_mem[stack_fill] = val;
                    stack_fill++;
                    queue_result(ST_OK, '0, stack_fill, 1'b1);
                end
            end
            REQ_POP, REQ_PEEK: begin
                if (stack_fill == 0) begin
                    queue_result(ST_EMPTY, '0, 0, 1'b1);
                    o_empty_hits++;
                end else if (req == REQ_POP) begin
                    stack_fill--;
                    queue_result(ST_OK, stack_mem[stack_fill], stack_fill, 1'b1);
                end else begin
                    queue_result(ST_OK, stack_mem[stack_fill-1], stack_fill, 1'b1);
                end
            end
            REQ_CLEAR: begin
                stack_fill = 0;
                queue_result(ST_OK, '0, 0, 1'b1);
            end
            REQ_TRAVERSE: begin
                for (int i = 0; i < stack_fill; i++) begin
                    idx = dir ? (stack_fill - 1 - i) : i;
                    queue_result(ST_OK, stack_mem[idx], stack_fill, (i + 1 == stack_fill));
                end
            end
            default: ;  // unused codes: no effect
        endcase
    endtask

    always @(posedge i_clk) begin
        t_stack_result w;
        if (!i_rst_n) begin
            stack_fill = 0;
            awaited_q.delete();
        end else begin
            // results first: a result never belongs to a transfer at the same edge
            if (i_valid) begin
                o_result_count++;
                if (awaited_q.size() == 0) begin
                    report_mismatch("unexpected result, status", 32'(i_status), 32'hx);
                end else begin
                    w = awaited_q.pop_front();
                    if (i_status !== w.status)
                        report_mismatch("status", 32'(i_status), 32'(w.status));
                    if (i_out_value !== w.value)
                        report_mismatch("out_value", i_out_value, w.value);
                    if (i_depth_now !== w.depth)
                        report_mismatch("depth_now", 32'(i_depth_now), 32'(w.depth));
                    if (i_last_of_run !== w.last)
                        report_mismatch("last_of_run", 32'(i_last_of_run), 32'(w.last));
                end
            end
            if (i_start && !i_busy)
                predict_request(i_req_type, i_push_value, i_traverse_dir);
        end
        o_pending = awaited_q.size();
    end

endmodule

// ----- tb/lifo_stack_engine_test.sv -----
// Testbench top for the LIFO stack engine: stimulus, reset, clock and verdict.
module lifo_stack_engine_test;
    import lse_pkg::*;

    localparam int DEPTH     = STACK_DEPTH_DEF;
    localparam int MAX_GAP   = 13;
    localparam int SETTLE    = 8;     // cycles after drain for trailing empty traverses
    localparam int TAIL      = 80;    // > longest traverse
    localparam int DRAIN_MAX = 20000;

    // request codes the block must ignore
    localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_start        = 1'b0;
    logic [REQ_W-1:0]        i_req_type     = REQ_PUSH;
    logic [VAL_W-1:0]        i_push_value   = '0;
    logic                    i_traverse_dir = 1'b0;
    logic                    o_busy;
    logic                    o_valid;
    logic [STAT_W-1:0]       o_status;
    logic [VAL_W-1:0]        o_out_value;
    logic [DEPTH_OUT_W-1:0]  o_depth_now;
    logic                    o_last_of_run;

    int fail_count, pending, result_count, full_hits, empty_hits;

    // per request code, how many were transferred
    int  sent_by_code [8];
    bit  no_idle;             // burst mode: back-to-back requests

    always #5 i_clk = ~i_clk;

    lifo_stack_engine u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_req_type     (i_req_type),
        .i_push_value   (i_push_value),
        .i_traverse_dir (i_traverse_dir),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_out_value    (o_out_value),
        .o_depth_now    (o_depth_now),
        .o_last_of_run  (o_last_of_run)
    );

    lse_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_busy         (o_busy),
        .i_req_type     (i_req_type),
        .i_push_value   (i_push_value),
        .i_traverse_dir (i_traverse_dir),
        .i_valid        (o_valid),
        .i_status       (o_status),
        .i_out_value    (o_out_value),
        .i_depth_now    (o_depth_now),
        .i_last_of_run  (o_last_of_run),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_full_hits    (full_hits),
        .o_empty_hits   (empty_hits)
    );

    // Hold one request on the ports until the block takes it. Called on a
    // rising-edge step; returns on the step of the edge that made the transfer.
    // The transfer condition is sampled at the falling edge, where nothing
    // moves, so there is no race against the block's own updates.
    task automatic issue_request(input logic [REQ_W-1:0] req,
                                 input logic [VAL_W-1:0] val, input logic dir);
        int  gap;
        bit  taken;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_start        <= 1'b0;
            // junk on the payload while idle
            i_req_type     <= REQ_W'($urandom);
            i_push_value   <= $urandom;
            i_traverse_dir <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        i_req_type     <= req;
        i_push_value   <= val;
        i_traverse_dir <= dir;
        i_start        <= 1'b1;
        do begin
            @(negedge i_clk);
            taken = i_start && !o_busy;
            @(posedge i_clk);
        end while (!taken);
        sent_by_code[req]++;
    endtask

    // Stop sending until every outstanding result has come back.
    task automatic wait_drained();
        int n;
        i_start <= 1'b0;
        n = 0;
        @(negedge i_clk);
        while (pending != 0 && n < DRAIN_MAX) begin
            @(negedge i_clk);
            n++;
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            3:       return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    // per random round: push share in percent, and whether clears may appear
    int  push_pct [6] = '{90, 90, 10, 50, 85, 20};
    bit  clear_ok [6] = '{0, 0, 1, 1, 0, 1};

    initial begin
        int               counted, r;
        logic [REQ_W-1:0] req;

        no_idle = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty-stack cases, data extremes, both traverse orders,
        // ignored codes, clear and reuse after clear
        issue_request(REQ_POP,      '0,            1'b0);
        issue_request(REQ_PEEK,     '0,            1'b0);
        issue_request(REQ_TRAVERSE, '0,            1'b0);
        issue_request(REQ_TRAVERSE, '1,            1'b1);
        issue_request(REQ_PUSH,     '0,            1'b0);
        issue_request(REQ_PUSH,     '1,            1'b1);
        issue_request(REQ_PUSH,     32'hA5A5_A5A5, 1'b0);
        issue_request(REQ_PUSH,     32'h5A5A_5A5A, 1'b1);
        issue_request(REQ_PEEK,     '0,            1'b0);
        issue_request(REQ_TRAVERSE, '0,            1'b0);
        issue_request(REQ_TRAVERSE, '0,            1'b1);
        issue_request(REQ_POP,      '0,            1'b0);
        issue_request(REQ_UNUSED_LO, 32'hDEAD_BEEF, 1'b1);
        issue_request(REQ_UNUSED_HI, 32'h1234_5678, 1'b0);
        issue_request(REQ_POP,      '0,            1'b0);
        issue_request(REQ_PEEK,     '0,            1'b1);
        issue_request(REQ_CLEAR,    '0,            1'b0);
        issue_request(REQ_POP,      '0,            1'b0);
        issue_request(REQ_TRAVERSE, '0,            1'b1);
        issue_request(REQ_PUSH,     32'h0000_0001, 1'b0);
        issue_request(REQ_TRAVERSE, '0,            1'b1);
        issue_request(REQ_CLEAR,    '0,            1'b0);
        wait_drained();

        // random: rounds alternate between filling (to reach full and push
        // refusals) and draining (to hit empty again), with mixed rounds in
        // between; ignored codes are sprinkled in but not counted
        for (int rnd = 0; rnd < 6; rnd++) begin
            counted = 0;
            while (counted < 45) begin
                if ($urandom_range(0, 19) == 0)
                    no_idle = ~no_idle;
                r = $urandom_range(0, 99);
                if (r < push_pct[rnd]) begin
                    req = REQ_PUSH;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 45)                  req = REQ_POP;
                    else if (r < 68)             req = REQ_PEEK;
                    else if (r < 88)             req = REQ_TRAVERSE;
                    else if (r < 94)             req = clear_ok[rnd] ? REQ_CLEAR : REQ_PEEK;
                    else                         req = REQ_W'($urandom_range(
                                                     REQ_UNUSED_LO, REQ_UNUSED_HI));
                end
                issue_request(req, pick_value(), 1'($urandom));
                if (req <= REQ_TRAVERSE)
                    counted++;
            end
            // hold off once mid-run with the stack near full
            if (rnd == 1)
                wait_drained();
        end

        wait_drained();
        repeat (TAIL) @(posedge i_clk);

        $display({"covered %0d requests: push %0d, pop %0d, peek %0d, clear %0d, ",
                  "traverse %0d, ignored %0d"},
                 sent_by_code[REQ_PUSH] + sent_by_code[REQ_POP] + sent_by_code[REQ_PEEK]
                 + sent_by_code[REQ_CLEAR] + sent_by_code[REQ_TRAVERSE],
                 sent_by_code[REQ_PUSH], sent_by_code[REQ_POP], sent_by_code[REQ_PEEK],
                 sent_by_code[REQ_CLEAR], sent_by_code[REQ_TRAVERSE],
                 sent_by_code[5] + sent_by_code[6] + sent_by_code[7]);
        $display("checked %0d results, %0d push refusals on full, %0d empty pop/peek",
                 result_count, full_hits, empty_hits);
        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("timeout");
        $display("simulation failed");
        $finish;
    end

endmodule
